// ----- sv/ffsra_pkg.sv -----
// ----------------------------------------------------------------------------
// ffsra_pkg
// Shared types, sizes, status codes and datapath command codes of the
// first-fit slot range allocator.
// ----------------------------------------------------------------------------
package ffsra_pkg;

    localparam int SLOTS_PER_PAGE = 256;
    localparam int MAX_EXTENTS    = 128;
    localparam int MAX_PAGES      = 4;

    localparam int PAGE_W  = $clog2(MAX_PAGES);
    localparam int PCNT_W  = $clog2(MAX_PAGES + 1);
    localparam int IDX_W   = $clog2(MAX_EXTENTS);
    localparam int CNT_W   = $clog2(MAX_EXTENTS + 1);
    localparam int LEN_W   = $clog2(SLOTS_PER_PAGE + 1);
    localparam int ADDR_W  = PAGE_W + IDX_W;
    localparam int DEPTH   = MAX_PAGES * MAX_EXTENTS;
    localparam int TOTAL_W = 11;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_SPACE   = 3'd1;
    localparam logic [2:0] ST_WRONG_PAGE = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL = 3'd3;
    localparam logic [2:0] ST_BAD_FREE   = 3'd4;

    localparam logic [3:0] OP_IDLE     = 4'd0;
    localparam logic [3:0] OP_CFG      = 4'd1;
    localparam logic [3:0] OP_FILL     = 4'd2;
    localparam logic [3:0] OP_LOAD     = 4'd3;
    localparam logic [3:0] OP_NEXT_PG  = 4'd4;
    localparam logic [3:0] OP_READ     = 4'd5;
    localparam logic [3:0] OP_A_EVAL   = 4'd6;
    localparam logic [3:0] OP_NOSPACE  = 4'd7;
    localparam logic [3:0] OP_F_PRE    = 4'd8;
    localparam logic [3:0] OP_F_EVAL   = 4'd9;
    localparam logic [3:0] OP_F_DECIDE = 4'd10;
    localparam logic [3:0] OP_SD_READ  = 4'd11;
    localparam logic [3:0] OP_SD_WRITE = 4'd12;
    localparam logic [3:0] OP_SD_END   = 4'd13;
    localparam logic [3:0] OP_SU_READ  = 4'd14;
    localparam logic [3:0] OP_SU_WRITE = 4'd15;

    typedef struct packed {
        logic       mode;
        logic [8:0] count;
        logic [1:0] page_index;
        logic [7:0] start_slot;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  granted_page;
        logic [7:0]  granted_slot;
        logic [10:0] free_total;
    } out_t;

    typedef struct packed {
        logic [LEN_W-1:0] start;
        logic [LEN_W-1:0] length;
    } ext_t;

    typedef struct packed {
        logic [3:0] op;
        logic       su_end;
    } cmd_t;

    typedef struct packed {
        logic fill_done;
        logic page_end;
        logic idx_end;
        logic a_fit;
        logic a_empty;
        logic pre_done;
        logic f_lt;
        logic dec_remove;
        logic dec_insert;
        logic sd_end;
        logic su_end;
    } sts_t;

endpackage

// ----- sv/ffsra_ram.sv -----
// ----------------------------------------------------------------------------
// ffsra_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffsra_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- sv/ffsra_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffsra_ctrl
// Controller: sequences page fill, allocate scan, free search, list shifts
// and the result handshake by issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module ffsra_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_mode,
    output logic               s_ready,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  ffsra_pkg::sts_t    sts,
    output ffsra_pkg::cmd_t    cmd
);
    import ffsra_pkg::*;

    localparam logic [3:0] S_FILL = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_ARD  = 4'd2;
    localparam logic [3:0] S_AEV  = 4'd3;
    localparam logic [3:0] S_FPRE = 4'd4;
    localparam logic [3:0] S_FRD  = 4'd5;
    localparam logic [3:0] S_FEV  = 4'd6;
    localparam logic [3:0] S_FDEC = 4'd7;
    localparam logic [3:0] S_SDRD = 4'd8;
    localparam logic [3:0] S_SDWR = 4'd9;
    localparam logic [3:0] S_SURD = 4'd10;
    localparam logic [3:0] S_SUWR = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0] state_reg, state_next;

    // handshakes
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign m_valid   = (state_reg == S_OUT);

    // next state and command
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_IDLE;
        cmd.su_end = 1'b0;
        case (state_reg)
            S_FILL: begin
                if (sts.fill_done) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.op = OP_FILL;
                end
            end
            S_IDLE: begin
                if (cfg_valid) begin
                    cmd.op     = OP_CFG;
                    state_next = S_FILL;
                end else if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = s_mode ? S_FPRE : S_ARD;
                end
            end
            S_ARD: begin
                if (sts.page_end) begin
                    cmd.op     = OP_NOSPACE;
                    state_next = S_OUT;
                end else if (sts.idx_end) begin
                    cmd.op = OP_NEXT_PG;
                end else begin
                    cmd.op     = OP_READ;
                    state_next = S_AEV;
                end
            end
            S_AEV: begin
                cmd.op = OP_A_EVAL;
                if (sts.a_fit) begin
                    state_next = sts.a_empty ? S_SDRD : S_OUT;
                end else begin
                    state_next = S_ARD;
                end
            end
            S_FPRE: begin
                cmd.op     = OP_F_PRE;
                state_next = sts.pre_done ? S_OUT : S_FRD;
            end
            S_FRD: begin
                if (sts.idx_end) begin
                    state_next = S_FDEC;
                end else begin
                    cmd.op     = OP_READ;
                    state_next = S_FEV;
                end
            end
            S_FEV: begin
                cmd.op     = OP_F_EVAL;
                state_next = sts.f_lt ? S_FRD : S_FDEC;
            end
            S_FDEC: begin
                cmd.op = OP_F_DECIDE;
                if (sts.dec_remove) begin
                    state_next = S_SDRD;
                end else if (sts.dec_insert) begin
                    state_next = S_SURD;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_SDRD: begin
                if (sts.sd_end) begin
                    cmd.op     = OP_SD_END;
                    state_next = S_OUT;
                end else begin
                    cmd.op     = OP_SD_READ;
                    state_next = S_SDWR;
                end
            end
            S_SDWR: begin
                cmd.op     = OP_SD_WRITE;
                state_next = S_SDRD;
            end
            S_SURD: begin
                cmd.op = OP_SU_READ;
                if (sts.su_end) begin
                    cmd.su_end = 1'b1;
                    state_next = S_OUT;
                end else begin
                    state_next = S_SUWR;
                end
            end
            S_SUWR: begin
                cmd.op     = OP_SU_WRITE;
                state_next = S_SURD;
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register; reset starts with the page fill pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_FILL;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// ----- sv/ffsra_dp.sv -----
// ----------------------------------------------------------------------------
// ffsra_dp
// Datapath: extent RAM, per-page counts and free sums, scan indexes,
// neighbour registers and result registers, driven by controller commands.
// ----------------------------------------------------------------------------
module ffsra_dp (
    input  logic             aclk,
    input  logic             aresetn,
    input  ffsra_pkg::cmd_t  cmd,
    input  ffsra_pkg::in_t   s_data,
    input  logic [2:0]       cfg_data,
    output ffsra_pkg::sts_t  sts,
    output ffsra_pkg::out_t  m_data
);
    import ffsra_pkg::*;

    localparam logic [LEN_W-1:0]  FULL_LEN = LEN_W'(SLOTS_PER_PAGE);
    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_EXTENTS);
    localparam logic [PCNT_W-1:0] PG_MAX   = PCNT_W'(MAX_PAGES);

    // request, indexes, bookkeeping
    logic [8:0]        n_reg;
    logic [7:0]        slot_reg;
    logic [PCNT_W-1:0] p_reg;
    logic [CNT_W-1:0]  e_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [PCNT_W-1:0] piu_reg;
    logic [PCNT_W-1:0] fill_pg_reg;
    logic [PCNT_W-1:0] fill_end_reg;
    logic [CNT_W-1:0]  cnt_reg  [MAX_PAGES];
    logic [LEN_W-1:0]  psum_reg [MAX_PAGES];
    ext_t              prev_reg, next_reg;
    logic              has_prev_reg, has_next_reg;
    logic [2:0]        status_reg;
    logic [1:0]        gp_reg;
    logic [7:0]        gs_reg;

    logic [PAGE_W-1:0] pg;
    logic [CNT_W-1:0]  cur_cnt;
    logic [PCNT_W-1:0] cfg_pages;
    ext_t              rdata;
    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    ext_t              wdata;
    logic [9:0]        prev_end, slot_end, a_end;
    logic              f_bad, jp, jn, pre_wrong, pre_bad;
    logic [9:0]        join_len;
    logic [TOTAL_W-1:0] total;

    assign pg      = p_reg[PAGE_W-1:0];
    assign cur_cnt = cnt_reg[pg];

    // clamp the register value into 1..MAX_PAGES
    always_comb begin
        if (cfg_data == 3'd0) begin
            cfg_pages = PCNT_W'(1);
        end else if (PCNT_W'(cfg_data) > PG_MAX || cfg_data > 3'(MAX_PAGES)) begin
            cfg_pages = PG_MAX;
        end else begin
            cfg_pages = PCNT_W'(cfg_data);
        end
    end

    // free-range checks against the neighbouring extents
    assign prev_end  = 10'(prev_reg.start) + 10'(prev_reg.length);
    assign slot_end  = 10'(slot_reg) + 10'(n_reg);
    assign a_end     = 10'(rdata.start) + 10'(n_reg);
    assign pre_wrong = (p_reg >= piu_reg);
    assign pre_bad   = (slot_end > 10'(SLOTS_PER_PAGE));
    assign f_bad = (has_next_reg && next_reg.start == LEN_W'(slot_reg))
                || (has_prev_reg && 10'(slot_reg) < prev_end)
                || (has_next_reg && slot_end > 10'(next_reg.start));
    assign jp = has_prev_reg && 10'(slot_reg) == prev_end;
    assign jn = has_next_reg && slot_end == 10'(next_reg.start);
    assign join_len = 10'(prev_reg.length) + 10'(n_reg)
                    + (jn ? 10'(next_reg.length) : 10'd0);

    // status to the controller
    always_comb begin
        sts.fill_done  = (fill_pg_reg >= fill_end_reg);
        sts.page_end   = (p_reg >= piu_reg);
        sts.idx_end    = (e_reg >= cur_cnt);
        sts.a_fit      = (rdata.length >= n_reg) && (a_end <= 10'(SLOTS_PER_PAGE));
        sts.a_empty    = (rdata.length == n_reg);
        sts.pre_done   = pre_wrong || pre_bad || (n_reg == 9'd0);
        sts.f_lt       = (rdata.start < LEN_W'(slot_reg));
        sts.dec_remove = !f_bad && jp && jn;
        sts.dec_insert = !f_bad && !jp && !jn && (cur_cnt < CNT_MAX);
        sts.sd_end     = ((CNT_W+1)'(e_reg) + 1'b1) >= (CNT_W+1)'(cur_cnt);
        sts.su_end     = (k_reg == e_reg);
    end

    // RAM address and write selection
    always_comb begin
        we    = 1'b0;
        waddr = {pg, e_reg[IDX_W-1:0]};
        wdata = rdata;
        raddr = {pg, e_reg[IDX_W-1:0]};
        case (cmd.op)
            OP_FILL: begin
                we    = 1'b1;
                waddr = {fill_pg_reg[PAGE_W-1:0], IDX_W'(0)};
                wdata = '{start: '0, length: FULL_LEN};
            end
            OP_A_EVAL: begin
                we    = sts.a_fit;
                wdata = '{start: a_end[LEN_W-1:0],
                          length: rdata.length - n_reg};
            end
            OP_F_DECIDE: begin
                we = !f_bad && (jp || jn);
                if (jp) begin
                    waddr = {pg, IDX_W'(e_reg - 1'b1)};
                    wdata = '{start: prev_reg.start, length: join_len[LEN_W-1:0]};
                end else begin
                    wdata = '{start: LEN_W'(slot_reg),
                              length: next_reg.length + n_reg};
                end
            end
            OP_SD_READ: begin
                raddr = {pg, IDX_W'(e_reg + 1'b1)};
            end
            OP_SD_WRITE: begin
                we = 1'b1;
            end
            OP_SU_READ: begin
                raddr = {pg, IDX_W'(k_reg - 1'b1)};
                if (cmd.su_end) begin
                    we    = 1'b1;
                    wdata = '{start: LEN_W'(slot_reg), length: n_reg};
                end
            end
            OP_SU_WRITE: begin
                we    = 1'b1;
                waddr = {pg, k_reg[IDX_W-1:0]};
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    ffsra_ram #(
        .WIDTH ($bits(ext_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // control registers under reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            piu_reg      <= PCNT_W'(1);
            fill_pg_reg  <= '0;
            fill_end_reg <= PG_MAX;
        end else begin
            case (cmd.op)
                OP_CFG: begin
                    piu_reg      <= cfg_pages;
                    fill_pg_reg  <= piu_reg;
                    fill_end_reg <= cfg_pages;
                end
                OP_FILL: begin
                    fill_pg_reg <= fill_pg_reg + 1'b1;
                end
                default: begin
                    piu_reg <= piu_reg;
                end
            endcase
        end
    end

    // execute datapath commands
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_FILL: begin
                cnt_reg[fill_pg_reg[PAGE_W-1:0]]  <= CNT_W'(1);
                psum_reg[fill_pg_reg[PAGE_W-1:0]] <= FULL_LEN;
            end
            OP_LOAD: begin
                n_reg        <= s_data.count;
                slot_reg     <= s_data.start_slot;
                p_reg        <= s_data.mode ? PCNT_W'(s_data.page_index) : '0;
                e_reg        <= '0;
                has_prev_reg <= 1'b0;
                has_next_reg <= 1'b0;
                status_reg   <= ST_OK;
                gp_reg       <= '0;
                gs_reg       <= '0;
            end
            OP_NEXT_PG: begin
                p_reg <= p_reg + 1'b1;
                e_reg <= '0;
            end
            OP_A_EVAL: begin
                if (sts.a_fit) begin
                    gp_reg       <= pg;
                    gs_reg       <= rdata.start[7:0];
                    psum_reg[pg] <= psum_reg[pg] - n_reg;
                end else begin
                    e_reg <= e_reg + 1'b1;
                end
            end
            OP_NOSPACE: begin
                status_reg <= ST_NO_SPACE;
            end
            OP_F_PRE: begin
                if (pre_wrong) begin
                    status_reg <= ST_WRONG_PAGE;
                end else if (pre_bad) begin
                    status_reg <= ST_BAD_FREE;
                end
            end
            OP_F_EVAL: begin
                if (sts.f_lt) begin
                    prev_reg     <= rdata;
                    has_prev_reg <= 1'b1;
                    e_reg        <= e_reg + 1'b1;
                end else begin
                    next_reg     <= rdata;
                    has_next_reg <= 1'b1;
                end
            end
            OP_F_DECIDE: begin
                if (f_bad) begin
                    status_reg <= ST_BAD_FREE;
                end else if (jp || jn || cur_cnt < CNT_MAX) begin
                    psum_reg[pg] <= psum_reg[pg] + n_reg;
                    k_reg        <= cur_cnt;
                end else begin
                    status_reg <= ST_TABLE_FULL;
                end
            end
            OP_SD_WRITE: begin
                e_reg <= e_reg + 1'b1;
            end
            OP_SD_END: begin
                cnt_reg[pg] <= cur_cnt - 1'b1;
            end
            OP_SU_READ: begin
                if (cmd.su_end) begin
                    cnt_reg[pg] <= cur_cnt + 1'b1;
                end
            end
            OP_SU_WRITE: begin
                k_reg <= k_reg - 1'b1;
            end
            default: begin
                k_reg <= k_reg;
            end
        endcase
    end

    // sum the free counts of the active pages
    always_comb begin
        total = '0;
        for (int i = 0; i < MAX_PAGES; i++) begin
            if (PCNT_W'(i) < piu_reg) begin
                total = total + TOTAL_W'(psum_reg[i]);
            end
        end
    end

    assign m_data.status       = status_reg;
    assign m_data.granted_page = gp_reg;
    assign m_data.granted_slot = gs_reg;
    assign m_data.free_total   = total;
endmodule

// ----- sv/first_fit_slot_range_allocator_core.sv -----
// ----------------------------------------------------------------------------
// first_fit_slot_range_allocator_core
// First-fit slot range allocator over chained pages of sorted free extents,
// with coalescing on free and a free total on every result.
//
//   channel  direction  signals                       payload
//   s_       in         s_valid s_ready s_data        in_t request
//   m_       out        m_valid m_ready m_data        out_t result
//   cfg_     in         cfg_valid cfg_ready cfg_data  pages_in_use
//
// One request at a time. Allocate reads and evaluates each extent scanned and
// steps from page to page; free reads and evaluates each extent passed in its
// page; a removal or insertion adds a read and a write per entry shifted, all
// set by the one registered read port of the extent RAM. Result is held until m_ready.
// After reset a pass writes entry 0 of each page, and a register write
// fills each newly active page; s_ready is low meanwhile.
// ----------------------------------------------------------------------------
module first_fit_slot_range_allocator_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ffsra_pkg::in_t    s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ffsra_pkg::out_t   m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_data
);
    import ffsra_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequence the work
    ffsra_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_mode    (s_data.mode),
        .s_ready   (s_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // hold the extent tables and results
    ffsra_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_data   (s_data),
        .cfg_data (cfg_data),
        .sts      (sts),
        .m_data   (m_data)
    );
endmodule

// ----- tb/first_fit_slot_range_allocator_core_tb.sv -----
// ----------------------------------------------------------------------------
// first_fit_slot_range_allocator_core_tb
// Drives allocate and free requests through the slot range allocator with
// bursty sending and a stalling receiver. Every result is checked field by
// field against a behavioural predictor of the extent tables. The page count
// register is swept between phases while the block is idle.
// ----------------------------------------------------------------------------
module first_fit_slot_range_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffsra_pkg::*;

    localparam int CYCLE_LIMIT = 10_000_000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_data;

    first_fit_slot_range_allocator_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Predictor state: shadow extent tables
    int unsigned ext_start [MAX_PAGES][MAX_EXTENTS];
    int unsigned ext_len   [MAX_PAGES][MAX_EXTENTS];
    int unsigned ext_cnt   [MAX_PAGES];
    int unsigned active_pages;

    out_t pending_results[$];
    int   mismatches;
    int   cycles;
    bit   finished;

    // Directed stimulus table; check_row set means want_row holds the result
    typedef struct {
        in_t  req;
        bit   check_row;
        out_t want_row;
    } dir_row_t;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Stop the run if it hangs
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic void page_reset(int unsigned p);
        ext_start[p][0] = 0;
        ext_len[p][0] = SLOTS_PER_PAGE;
        ext_cnt[p] = 1;
    endfunction

    function automatic int unsigned free_slots_total();
        int unsigned s;
        s = 0;
        for (int p = 0; p < active_pages; p++)
            for (int e = 0; e < ext_cnt[p]; e++) s += ext_len[p][e];
        return s;
    endfunction

    function automatic void drop_extent(int unsigned p, int unsigned e);
        for (int unsigned i = e; i + 1 < ext_cnt[p]; i++) begin
            ext_start[p][i] = ext_start[p][i + 1];
            ext_len[p][i] = ext_len[p][i + 1];
        end
        ext_cnt[p]--;
    endfunction

    function automatic void apply_page_count(logic [2:0] v);
        int unsigned n;
        n = v;
        if (n < 1) n = 1;
        if (n > MAX_PAGES) n = MAX_PAGES;
        for (int unsigned p = active_pages; p < n; p++) page_reset(p);
        active_pages = n;
    endfunction

    function automatic logic [2:0] grant_range(int unsigned n, ref out_t r);
        for (int unsigned p = 0; p < active_pages; p++)
            for (int unsigned e = 0; e < ext_cnt[p]; e++)
                if (ext_len[p][e] >= n && ext_start[p][e] + n <= SLOTS_PER_PAGE) begin
                    r.granted_page = 2'(p);
                    r.granted_slot = 8'(ext_start[p][e]);
                    ext_start[p][e] += n;
                    ext_len[p][e] -= n;
                    if (ext_len[p][e] == 0) drop_extent(p, e);
                    return ST_OK;
                end
        return ST_NO_SPACE;
    endfunction

    function automatic logic [2:0] release_range(int unsigned p, int unsigned slot,
                                                 int unsigned n);
        int unsigned cnt, pos;
        bit has_prev, has_next, join_prev, join_next;
        if (p >= active_pages) return ST_WRONG_PAGE;
        if (slot >= SLOTS_PER_PAGE || slot + n > SLOTS_PER_PAGE) return ST_BAD_FREE;
        if (n == 0) return ST_OK;
        cnt = ext_cnt[p];
        pos = 0;
        while (pos < cnt && ext_start[p][pos] < slot) pos++;
        has_prev = pos > 0;
        has_next = pos < cnt;
        if (has_next && ext_start[p][pos] == slot) return ST_BAD_FREE;
        if (has_prev && slot < ext_start[p][pos-1] + ext_len[p][pos-1]) return ST_BAD_FREE;
        if (has_next && slot + n > ext_start[p][pos]) return ST_BAD_FREE;
        join_prev = has_prev && slot == ext_start[p][pos-1] + ext_len[p][pos-1];
        join_next = has_next && slot + n == ext_start[p][pos];
        if (join_prev && join_next) begin
            ext_len[p][pos-1] += n + ext_len[p][pos];
            drop_extent(p, pos);
        end else if (join_next) begin
            ext_start[p][pos] = slot;
            ext_len[p][pos] += n;
        end else if (join_prev) begin
            ext_len[p][pos-1] += n;
        end else begin
            if (cnt >= MAX_EXTENTS) return ST_TABLE_FULL;
            for (int unsigned i = cnt; i > pos; i--) begin
                ext_start[p][i] = ext_start[p][i-1];
                ext_len[p][i] = ext_len[p][i-1];
            end
            ext_start[p][pos] = slot;
            ext_len[p][pos] = n;
            ext_cnt[p] = cnt + 1;
        end
        return ST_OK;
    endfunction

    function automatic out_t predict_result(in_t req);
        out_t r;
        r = '0;
        if (req.mode == 1'b0) begin
            r.status = grant_range(req.count, r);
            if (r.status != ST_OK) begin
                r.granted_page = '0;
                r.granted_slot = '0;
            end
        end else begin
            r.status = release_range(req.page_index, req.start_slot, req.count);
        end
        r.free_total = 11'(free_slots_total());
        return r;
    endfunction

    // Receiver: stall pattern of its own, check each result transaction
    logic [6:0] stall_phase;
    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_phase <= '0;
        end else begin
            stall_phase <= stall_phase + 1'b1;
            if (stall_phase[6])
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(0, 3) != 0) && !(stall_phase[4:3] == 2'b11);
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch("status", int'(m_data.status), int'(want.status));
                    if (m_data.granted_page !== want.granted_page)
                        report_mismatch("granted_page", int'(m_data.granted_page),
                                        int'(want.granted_page));
                    if (m_data.granted_slot !== want.granted_slot)
                        report_mismatch("granted_slot", int'(m_data.granted_slot),
                                        int'(want.granted_slot));
                    if (m_data.free_total !== want.free_total)
                        report_mismatch("free_total", int'(m_data.free_total),
                                        int'(want.free_total));
                end
            end
        end
    end

    // Send one request transaction and queue its prediction
    task automatic send_request(input in_t req, input bit check_row, input out_t want_row);
        out_t r;
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        r = predict_result(req);
        if (check_row && r != want_row)
            report_mismatch("directed row vs predictor", int'(r), int'(want_row));
        pending_results.push_back(r);
    endtask

    task automatic go_idle(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain_results();
        go_idle(0);
        while (pending_results.size() != 0) @(posedge aclk);
        // let any trailing work settle before register writes
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_page_count(input logic [2:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_page_count(v);
    endtask

    function automatic in_t make_req(logic mode, int unsigned n, int unsigned pg,
                                     int unsigned slot);
        in_t q;
        q.mode = mode;
        q.count = 9'(n);
        q.page_index = 2'(pg);
        q.start_slot = 8'(slot);
        return q;
    endfunction

    function automatic out_t make_res(logic [2:0] st, int unsigned pg, int unsigned slot,
                                      int unsigned tot);
        out_t r;
        r.status = st;
        r.granted_page = 2'(pg);
        r.granted_slot = 8'(slot);
        r.free_total = 11'(tot);
        return r;
    endfunction

    // Random request: mostly well-formed allocations and frees of held ranges
    typedef struct { int unsigned pg; int unsigned slot; int unsigned n; } held_t;
    held_t held[$];

    function automatic in_t random_req();
        in_t q;
        int unsigned k, pick, part;
        k = $urandom_range(0, 99);
        if (k < 45) begin
            if ($urandom_range(0, 9) == 0) q = make_req(1'b0, $urandom_range(0, 511), 0, 0);
            else q = make_req(1'b0, $urandom_range(0, 24), 0, 0);
            q.page_index = 2'($urandom);
            q.start_slot = 8'($urandom);
        end else if (k < 85 && held.size() != 0) begin
            pick = $urandom_range(0, held.size() - 1);
            part = $urandom_range(1, held[pick].n);
            q = make_req(1'b1, part, held[pick].pg, held[pick].slot + held[pick].n - part);
            if (part == held[pick].n) held.delete(pick);
            else held[pick].n -= part;
        end else begin
            q = in_t'(20'($urandom));
            q.count = 9'($urandom_range(0, 511));
        end
        return q;
    endfunction

    dir_row_t dir_rows[$];
    int       sent;
    int       burst;
    out_t     none;

    initial begin
        in_t q;
        out_t r;
        logic [2:0] page_counts[6];
        mismatches = 0;
        cycles = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        none = '0;
        page_counts = '{3'd0, 3'd2, 3'd7, 3'd1, 3'd3, 3'd4};
        for (int p = 0; p < MAX_PAGES; p++) page_reset(p);
        active_pages = 1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows
        dir_rows.push_back('{make_req(1'b0, 0, 3, 255), 1, make_res(ST_OK, 0, 0, 256)});
        dir_rows.push_back('{make_req(1'b0, 511, 0, 0), 1,
                             make_res(ST_NO_SPACE, 0, 0, 256)});
        dir_rows.push_back('{make_req(1'b0, 256, 0, 0), 1, make_res(ST_OK, 0, 0, 0)});
        dir_rows.push_back('{make_req(1'b0, 0, 0, 0), 1, make_res(ST_NO_SPACE, 0, 0, 0)});
        dir_rows.push_back('{make_req(1'b1, 1, 3, 0), 1,
                             make_res(ST_WRONG_PAGE, 0, 0, 0)});
        dir_rows.push_back('{make_req(1'b1, 2, 0, 255), 1,
                             make_res(ST_BAD_FREE, 0, 0, 0)});
        dir_rows.push_back('{make_req(1'b1, 0, 0, 9), 1, make_res(ST_OK, 0, 0, 0)});
        dir_rows.push_back('{make_req(1'b1, 10, 0, 100), 1, make_res(ST_OK, 0, 0, 10)});
        dir_rows.push_back('{make_req(1'b1, 4, 0, 100), 1,
                             make_res(ST_BAD_FREE, 0, 0, 10)});
        dir_rows.push_back('{make_req(1'b1, 4, 0, 105), 1,
                             make_res(ST_BAD_FREE, 0, 0, 10)});
        dir_rows.push_back('{make_req(1'b1, 5, 0, 96), 1,
                             make_res(ST_BAD_FREE, 0, 0, 10)});
        dir_rows.push_back('{make_req(1'b1, 5, 0, 110), 1, make_res(ST_OK, 0, 0, 15)});
        dir_rows.push_back('{make_req(1'b1, 5, 0, 95), 1, make_res(ST_OK, 0, 0, 20)});
        dir_rows.push_back('{make_req(1'b1, 1, 0, 200), 0, none});
        dir_rows.push_back('{make_req(1'b1, 1, 0, 202), 0, none});
        dir_rows.push_back('{make_req(1'b1, 1, 0, 201), 0, none});
        dir_rows.push_back('{make_req(1'b1, 1, 0, 0), 0, none});
        dir_rows.push_back('{make_req(1'b1, 1, 0, 255), 0, none});
        dir_rows.push_back('{make_req(1'b0, 4, 2, 170), 0, none});
        dir_rows.push_back('{make_req(1'b0, 30, 1, 85), 0, none});
        dir_rows.push_back('{make_req(1'b1, 256, 0, 0), 1,
                             make_res(ST_BAD_FREE, 0, 0, 21)});
        foreach (dir_rows[i]) begin
            q = dir_rows[i].req;
            // want_row free_total is only typed where it is read at a glance
            send_request(q, dir_rows[i].check_row, dir_rows[i].want_row);
        end
        drain_results();

        // Merge page 0 back to one extent, empty it, then free single slots
        // with one-slot gaps up to the table limit
        write_page_count(3'd1);
        send_request(make_req(1'b1, 98, 0, 1), 0, none);
        send_request(make_req(1'b1, 85, 0, 115), 0, none);
        send_request(make_req(1'b1, 52, 0, 203), 0, none);
        send_request(make_req(1'b0, 256, 0, 0), 0, none);
        for (int i = 0; i < MAX_EXTENTS; i++)
            send_request(make_req(1'b1, 1, 0, 2 * i), 0, none);
        drain_results();

        // Random phases over several page counts
        foreach (page_counts[ph]) begin
            write_page_count(page_counts[ph]);
            held.delete();
            sent = 0;
            while (sent < 170) begin
                burst = $urandom_range(1, 12);
                repeat (burst) begin
                    q = random_req();
                    send_request(q, 0, none);
                    r = pending_results[$];
                    if (q.mode == 1'b0 && r.status == ST_OK && q.count != 0)
                        held.push_back('{r.granted_page, r.granted_slot, q.count});
                    sent++;
                end
                if (sent % 60 < burst) begin
                    // hold off until every result is back
                    go_idle(0);
                    while (pending_results.size() != 0) @(posedge aclk);
                end else if ($urandom_range(0, 2) != 0) begin
                    go_idle($urandom_range(1, 40));
                end
            end
            drain_results();
        end

        go_idle(0);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
